// ===== design/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and the texel lighting function for the span shader.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TEX_BITS   = 6;
    localparam int MAX_SPAN   = 4095;
    localparam int ADDR_W     = 2 * TEX_BITS;
    localparam int TEX_WORDS  = 1 << ADDR_W;
    localparam int LEFT_W     = $clog2(MAX_SPAN + 1);
    localparam int TEXEL_W    = 16;
    localparam int S_TDATA_W  = 208;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SPAN  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [11:0] pixel_count;
        logic [15:0] fog_add;
        logic [7:0]  light_b;
        logic [7:0]  light_g;
        logic [7:0]  light_r;
        logic [31:0] v_step;
        logic [31:0] u_step;
        logic [31:0] v_start;
        logic [31:0] u_start;
        logic [15:0] tex_data;
        logic [11:0] tex_addr;
    } in_item_t;

    // per-pixel shading attributes carried alongside the texture read
    typedef struct packed {
        logic [7:0]  gain_r;
        logic [7:0]  gain_g;
        logic [7:0]  gain_b;
        logic [15:0] fog;
        logic        last;
    } px_info_t;

    // Each 5-bit channel times its 8-bit gain; the top five product bits land
    // back in the channel's field (bit 5 stays clear), then fog is added.
    function automatic logic [15:0] shade_texel(input logic [15:0] t,
                                                input px_info_t   info);
        logic [12:0] prod_b;
        logic [12:0] prod_g;
        logic [12:0] prod_r;
        logic [15:0] lit;
        prod_b = 13'(t[4:0])   * 13'(info.gain_b);
        prod_g = 13'(t[10:6])  * 13'(info.gain_g);
        prod_r = 13'(t[15:11]) * 13'(info.gain_r);
        lit    = {prod_r[12:8], prod_g[12:8], 1'b0, prod_b[12:8]};
        return lit + info.fog;
    endfunction

endpackage

// ===== design/tss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tss_span.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_span
// Span state: u/v accumulators, steps, gains, fog and pixel count. Decodes
// accepted transactions into texture writes and texture reads.
// ----------------------------------------------------------------------------
module tss_span import tss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  cmd_t              cmd,
    input  in_item_t          item,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [15:0]       wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output px_info_t          rd_info
);

    logic [31:0]       u_accum_reg, u_accum_next;
    logic [31:0]       v_accum_reg, v_accum_next;
    logic [31:0]       u_inc_reg,   u_inc_next;
    logic [31:0]       v_inc_reg,   v_inc_next;
    logic [7:0]        gain_r_reg,  gain_r_next;
    logic [7:0]        gain_g_reg,  gain_g_next;
    logic [7:0]        gain_b_reg,  gain_b_next;
    logic [15:0]       fog_reg,     fog_next;
    logic [LEFT_W-1:0] left_reg,    left_next;
    logic [LEFT_W-1:0] count_sat;
    logic              has_pixel;

    assign has_pixel = (left_reg != '0);

    always_comb begin
        if (32'(item.pixel_count) > 32'(MAX_SPAN)) begin
            count_sat = LEFT_W'(MAX_SPAN);
        end else begin
            count_sat = LEFT_W'(item.pixel_count);
        end
    end

    always_comb begin
        u_accum_next = u_accum_reg;
        v_accum_next = v_accum_reg;
        u_inc_next   = u_inc_reg;
        v_inc_next   = v_inc_reg;
        gain_r_next  = gain_r_reg;
        gain_g_next  = gain_g_reg;
        gain_b_next  = gain_b_reg;
        fog_next     = fog_reg;
        left_next    = left_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        if (accept) begin
            case (cmd)
                CMD_WRITE: begin
                    wr_en = 1'b1;
                end
                CMD_SPAN: begin
                    u_accum_next = item.u_start;
                    v_accum_next = item.v_start;
                    u_inc_next   = item.u_step;
                    v_inc_next   = item.v_step;
                    gain_r_next  = item.light_r;
                    gain_g_next  = item.light_g;
                    gain_b_next  = item.light_b;
                    fog_next     = item.fog_add;
                    left_next    = count_sat;
                end
                CMD_PIXEL: begin
                    if (has_pixel) begin
                        rd_en        = 1'b1;
                        left_next    = left_reg - 1'b1;
                        u_accum_next = u_accum_reg + u_inc_reg;
                        v_accum_next = v_accum_reg + v_inc_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign wr_addr = ADDR_W'(item.tex_addr);
    assign wr_data = item.tex_data;
    // row from the integer part of u, column from the integer part of v
    assign rd_addr = {u_accum_reg[FRAC_BITS +: TEX_BITS], v_accum_reg[FRAC_BITS +: TEX_BITS]};

    always_comb begin
        rd_info.gain_r = gain_r_reg;
        rd_info.gain_g = gain_g_reg;
        rd_info.gain_b = gain_b_reg;
        rd_info.fog    = fog_reg;
        rd_info.last   = (left_reg == LEFT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_accum_reg <= '0;
            v_accum_reg <= '0;
            u_inc_reg   <= '0;
            v_inc_reg   <= '0;
            gain_r_reg  <= '0;
            gain_g_reg  <= '0;
            gain_b_reg  <= '0;
            fog_reg     <= '0;
            left_reg    <= '0;
        end else begin
            u_accum_reg <= u_accum_next;
            v_accum_reg <= v_accum_next;
            u_inc_reg   <= u_inc_next;
            v_inc_reg   <= v_inc_next;
            gain_r_reg  <= gain_r_next;
            gain_g_reg  <= gain_g_next;
            gain_b_reg  <= gain_b_next;
            fog_reg     <= fog_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ===== design/tss_shade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_shade
// Texel read stage and output register: lights and fogs the texel returned
// by the texture RAM and holds the result for the master side.
// ----------------------------------------------------------------------------
module tss_shade import tss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        issue,
    input  px_info_t    issue_info,
    input  logic [15:0] texel,
    output logic        take_ok,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic        s1_valid_reg, s1_valid_next;
    px_info_t    s1_info_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_pixel_reg;
    logic        out_last_reg;
    logic        advance;

    // the read stage moves on whenever the output register is free or draining
    assign advance = !out_valid_reg || m_tready;
    assign take_ok = !s1_valid_reg || advance;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (issue) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_info_reg <= issue_info;
        end
        if (advance && s1_valid_reg) begin
            out_pixel_reg <= shade_texel(texel, s1_info_reg);
            out_last_reg  <= s1_info_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/textured_span_shader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_span_shader
// Affine texture-mapped span shader with per-channel gain and fog offset.
// ----------------------------------------------------------------------------
// Takes one transaction per clock in every command mix while m_tready holds
// high. A pixel transaction reads the simple dual-port texture RAM at the edge
// that accepts it; the shaded result is then registered in the output register,
// which drives m_tvalid, as soon as that register is free or draining. The read
// stage and the output register hold two pixels; with both full s_tready follows
// m_tready. A write and a read of the same texel in consecutive transactions
// need no forwarding since the read is accepted at a later edge than the write.
// Texel writes, span starts and pixel transactions past the end of a span
// produce no output. The texture RAM has no clearing pass; reading texels
// before they are written returns undefined data.
module textured_span_shader import tss_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tex_addr, tex_data, u_start, v_start, u_step, v_step, light_r, light_g,
    // light_b, fog_add, pixel_count
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    in_item_t          item;
    cmd_t              cmd;
    logic              accept;
    logic              take_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    px_info_t          rd_info;

    assign item     = in_item_t'(s_tdata);
    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = take_ok;
    assign accept   = s_tvalid && take_ok;

    tss_span u_span (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (cmd),
        .item    (item),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_info (rd_info)
    );

    tss_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEX_WORDS)
    ) u_tex_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tss_shade u_shade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (rd_en),
        .issue_info (rd_info),
        .texel      (rd_data),
        .take_ok    (take_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sim/tb_textured_span_shader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_textured_span_shader
// Self-checking bench for the textured span shader. A short directed table
// (texel extremes, coordinate wrap, empty and exhausted spans, restarts)
// is followed by randomized texture loads, spans and pixel transactions.
// Results are checked against a behavioral shader under random stalls on both
// stream interfaces.
// ----------------------------------------------------------------------------
module tb_textured_span_shader import tss_pkg::*;;

    localparam int DIR_ROWS   = 24;
    localparam int WORK_ITEMS = 1450 + DIR_ROWS;

    typedef struct packed {
        cmd_t        cmd;
        logic [11:0] addr;
        logic [15:0] texel;
        logic [31:0] u0;
        logic [31:0] v0;
        logic [31:0] du;
        logic [31:0] dv;
        logic [7:0]  gr;
        logic [7:0]  gg;
        logic [7:0]  gb;
        logic [15:0] fog;
        logic [11:0] cnt;
        logic        chk;    // pixel/last below are the expected result
        logic [15:0] px;
        logic        last;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] px;
        logic        last;
    } pixel_res_t;

    typedef struct {
        cmd_t       cmd;
        in_item_t   data;
        bit         typed;
        pixel_res_t want;
    } stim_t;

    // cmd, addr, texel, u_start, v_start, u_step, v_step, r, g, b, fog, count,
    // chk, pixel, last
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        // pixel before any span start
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        // unused command, all fields high
        '{CMD_NONE, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF, 1'b0, 16'h0, 1'b0},
        '{CMD_WRITE, 12'h000, 16'hFFFF, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_WRITE, 12'hFFF, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_WRITE, 12'h041, 16'h0841, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        // only the unused bit 5 set
        '{CMD_WRITE, 12'h042, 16'h0020, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'hFF, 8'hFF, 8'hFF, 16'h0000, 12'h001, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'hF79E, 1'b1},
        // span used up
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'hFFFF, 12'h001, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'hFFFF, 1'b1},
        // zero-length span
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'hFF, 8'hFF, 8'hFF, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        // corner texel, then both coordinates wrap to zero
        '{CMD_SPAN, 12'h000, 16'h0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000,
          32'h0001_0000, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 12'h002, 1'b0, 16'h0, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'hF79E, 1'b1},
        // column: u fixed, half-texel v step
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0001_0000, 32'h0001_8000, 32'h0,
          32'h0000_8000, 8'h80, 8'hC0, 8'hFF, 16'h8000, 12'h002, 1'b0, 16'h0, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0},
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'hFF, 8'hFF, 8'hFF, 16'h0000, 12'h003, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'hF79E, 1'b0},
        // restart before the running span is done
        '{CMD_SPAN, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h001, 1'b0, 16'h0000, 1'b0},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b1, 16'h0000, 1'b1},
        '{CMD_PIXEL, 12'h000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0,
          8'h00, 8'h00, 8'h00, 16'h0000, 12'h000, 1'b0, 16'h0000, 1'b0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // tex_addr, tex_data, u_start, v_start, u_step, v_step, light_r, light_g,
    // light_b, fog_add, pixel_count
    logic [S_TDATA_W-1:0] s_tdata;
    // cmd
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // pixel
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    textured_span_shader dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus plan and generator-side bookkeeping
    stim_t stim_q[$];
    bit    gen_written [TEX_WORDS];
    int    work_items = 0;

    // shader state as seen by the predictor
    logic [TEXEL_W-1:0] texel_mem [TEX_WORDS];
    logic [31:0]        u_acc = '0;
    logic [31:0]        v_acc = '0;
    logic [31:0]        u_inc = '0;
    logic [31:0]        v_inc = '0;
    logic [7:0]         gain_r = '0;
    logic [7:0]         gain_g = '0;
    logic [7:0]         gain_b = '0;
    logic [15:0]        fog_ofs = '0;
    logic [LEFT_W-1:0]  span_left = '0;
    pixel_res_t         pixel_expect_q[$];

    int send_idx     = 0;
    int idle_phase   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int cycle_limit  = 1000000;

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic in_item_t rand_fields();
        logic [223:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        return raw[S_TDATA_W-1:0];
    endfunction

    task automatic add_item(input cmd_t c, input in_item_t d, input bit typed,
                            input pixel_res_t want);
        stim_t s;
        s.cmd   = c;
        s.data  = d;
        s.typed = typed;
        s.want  = want;
        stim_q.push_back(s);
        if (c == CMD_WRITE)
            gen_written[d.tex_addr[ADDR_W-1:0]] = 1'b1;
        if (c != CMD_NONE)
            work_items++;
    endtask

    // One span: preload every texel it will touch, start it, then send pixel
    // transactions with the odd write or junk transaction mixed in.
    task automatic plan_span(input bit big);
        in_item_t          d;
        in_item_t          w;
        logic [31:0]       u;
        logic [31:0]       v;
        logic [ADDR_W-1:0] a;
        int                n;
        int                npx;
        int                pick;
        d = rand_fields();
        case ($urandom_range(3))
            0: ;
            1: d.u_step = '0;
            2: begin
                d.u_step = $urandom_range(0, 32'h3FFFF);
                d.v_step = $urandom_range(0, 32'h3FFFF);
            end
            default: d.v_step = '0;
        endcase
        if (roll(25))
            d.fog_add = '0;
        pick = $urandom_range(99);
        if (big) begin
            n = $urandom_range(400, 600);
            d.u_step = '0;
            d.v_step = $urandom_range(0, 32'h2FFFF);
        end else if (pick < 8) begin
            n = 0;
        end else if (pick < 75) begin
            n = $urandom_range(1, 12);
        end else if (pick < 95) begin
            n = $urandom_range(13, 64);
        end else begin
            n = $urandom_range(65, 300);
        end
        d.pixel_count = LEFT_W'(n);
        u = d.u_start;
        v = d.v_start;
        for (int i = 0; i < n; i++) begin
            a = {u[FRAC_BITS +: TEX_BITS], v[FRAC_BITS +: TEX_BITS]};
            if (!gen_written[a]) begin
                w = rand_fields();
                w.tex_addr = a;
                add_item(CMD_WRITE, w, 1'b0, '0);
            end
            u = u + d.u_step;
            v = v + d.v_step;
        end
        add_item(CMD_SPAN, d, 1'b0, '0);
        npx = roll(10) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
        for (int i = 0; i < npx; i++) begin
            if (roll(5))
                add_item(CMD_WRITE, rand_fields(), 1'b0, '0);
            if (roll(3))
                add_item(CMD_NONE, rand_fields(), 1'b0, '0);
            add_item(CMD_PIXEL, rand_fields(), 1'b0, '0);
        end
    endtask

    function automatic logic [15:0] light_texel(input logic [15:0] t);
        logic [31:0] blue;
        logic [31:0] green;
        logic [31:0] red;
        logic [31:0] lit;
        blue  = 32'(t & 16'h001F) * 32'(gain_b);
        green = (32'(t & 16'h07C0) * 32'(gain_g)) & 32'h0007_C000;
        red   = (32'(t & 16'hF800) * 32'(gain_r)) & 32'h00F8_0000;
        lit   = (blue | green | red) >> 8;
        return lit[15:0] + fog_ofs;
    endfunction

    // advance the shader state by one accepted transaction
    task automatic shade_transaction(input stim_t it);
        logic [ADDR_W-1:0] a;
        pixel_res_t        res;
        case (it.cmd)
            CMD_WRITE: begin
                texel_mem[it.data.tex_addr[ADDR_W-1:0]] = it.data.tex_data;
            end
            CMD_SPAN: begin
                u_acc   = it.data.u_start;
                v_acc   = it.data.v_start;
                u_inc   = it.data.u_step;
                v_inc   = it.data.v_step;
                gain_r  = it.data.light_r;
                gain_g  = it.data.light_g;
                gain_b  = it.data.light_b;
                fog_ofs = it.data.fog_add;
                span_left = (it.data.pixel_count > MAX_SPAN) ? LEFT_W'(MAX_SPAN)
                                                             : it.data.pixel_count;
            end
            CMD_PIXEL: begin
                if (span_left != '0) begin
                    a = {u_acc[FRAC_BITS +: TEX_BITS], v_acc[FRAC_BITS +: TEX_BITS]};
                    res.px   = light_texel(texel_mem[a]);
                    res.last = (span_left == LEFT_W'(1));
                    pixel_expect_q.push_back(it.typed ? it.want : res);
                    span_left = span_left - 1'b1;
                    u_acc = u_acc + u_inc;
                    v_acc = v_acc + v_inc;
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // input side: present, hold until the transaction is taken, idle at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                shade_transaction(stim_q[send_idx]);
                send_idx++;
            end
            idle_phase = (send_idx * 5) / stim_q.size();
            if (!s_tvalid || s_tready) begin
                if (send_idx < stim_q.size() &&
                    !((idle_phase == 1 && roll(86)) || (idle_phase == 3 && roll(36)))) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stim_q[send_idx].data;
                    s_tuser  <= stim_q[send_idx].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: check each pixel against the oldest expectation
    always @(posedge aclk) begin : pixel_check
        pixel_res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pixel_expect_q.size() == 0) begin
                    flag($sformatf("unexpected pixel %h last %b", m_tdata, m_tlast));
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (m_tdata !== want.px)
                        flag($sformatf("pixel exp %h got %h", want.px, m_tdata));
                    if (m_tlast !== want.last)
                        flag($sformatf("last exp %b got %b (pixel %h)",
                                       want.last, m_tlast, want.px));
                end
            end
            m_tready <= !((idle_phase == 2 && roll(86)) || (idle_phase == 3 && roll(36)));
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > cycle_limit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        in_item_t   d;
        pixel_res_t want;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_NONE;
        m_tready <= 1'b0;

        for (int r = 0; r < DIR_ROWS; r++) begin
            d = '0;
            d.tex_addr    = DIR_TBL[r].addr;
            d.tex_data    = DIR_TBL[r].texel;
            d.u_start     = DIR_TBL[r].u0;
            d.v_start     = DIR_TBL[r].v0;
            d.u_step      = DIR_TBL[r].du;
            d.v_step      = DIR_TBL[r].dv;
            d.light_r     = DIR_TBL[r].gr;
            d.light_g     = DIR_TBL[r].gg;
            d.light_b     = DIR_TBL[r].gb;
            d.fog_add     = DIR_TBL[r].fog;
            d.pixel_count = DIR_TBL[r].cnt;
            want.px       = DIR_TBL[r].px;
            want.last     = DIR_TBL[r].last;
            add_item(DIR_TBL[r].cmd, d, DIR_TBL[r].chk, want);
        end

        begin : random_plan
            bit big_done;
            big_done = 1'b0;
            while (work_items < WORK_ITEMS) begin
                if (roll(4))
                    add_item(CMD_NONE, rand_fields(), 1'b0, '0);
                if (roll(10))
                    add_item(CMD_WRITE, rand_fields(), 1'b0, '0);
                // one long column somewhere in the middle
                if (!big_done && work_items > WORK_ITEMS / 2) begin
                    plan_span(1'b1);
                    big_done = 1'b1;
                end else begin
                    plan_span(1'b0);
                end
            end
        end
        cycle_limit = 20000 + stim_q.size() * 100;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_idx < stim_q.size())
            @(posedge aclk);
        while (pixel_expect_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
